@@ rtl/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check, disabled while reset is high
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cause in one cycle, effect in the next
`define ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`endif

@@ rtl/xtea_pkg.sv @@
package xtea_pkg;

   localparam int unsigned NUM_CYCLES = 32;
   localparam int unsigned NUM_CELLS  = 2 * NUM_CYCLES;
   localparam logic [31:0] DELTA      = 32'h9E37_79B9;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_KEY_ZERO  = 2'd0;
   localparam logic [1:0] REG_KEY_ONE   = 2'd1;
   localparam logic [1:0] REG_KEY_TWO   = 2'd2;
   localparam logic [1:0] REG_KEY_THREE = 2'd3;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [3:0][31:0] key_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] v0;
      logic [31:0] v1;
   } item_type;

   // per-cell round constants
   typedef struct packed {
      logic        odd;
      logic [31:0] enc_sum;
      logic [31:0] dec_sum;
   } stage_type;

   function automatic logic [31:0] mix_word(input logic [31:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

   // even cells are the first half of a cycle, odd cells the second
   function automatic stage_type stage_const(input int unsigned idx);
      stage_type   s;
      int unsigned r;
      logic [63:0] enc_k;
      logic [63:0] dec_k;
      r = idx >> 1;
      s.odd = idx[0];
      if (idx[0]) begin
         enc_k = 64'(r + 1);
         dec_k = 64'(NUM_CYCLES - r - 1);
      end else begin
         enc_k = 64'(r);
         dec_k = 64'(NUM_CYCLES - r);
      end
      s.enc_sum = 32'(enc_k * 64'(DELTA));
      s.dec_sum = 32'(dec_k * 64'(DELTA));
      return s;
   endfunction

endpackage

@@ rtl/xtea_block_cipher.sv @@
// channel   dir  signals                         contents
// req       in   req_tvalid/tready/tdata/tuser   block halves and mode
// rsp       out  rsp_tvalid/tready/tdata         processed block halves
// csr       in   apb psel/penable/pwrite/paddr   four key words at 0x0..0xc
//
// a row of 64 half-round cells, two per xtea cycle; one item enters per clock while the row is not stalled
// each item passes the cell row registers and then the skid output register before rsp_tvalid
// reset is synchronous and clears valid flags and key words
// the row stalls as a whole only when both slots of the output skid stage are full
// so an item is still taken while one finished result waits on rsp
module xtea_block_cipher import xtea_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // block_low[31:0], block_high[63:32]
   input  logic                  req_tuser,   // req_type (0 encrypt, 1 decrypt)
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // out_low[31:0], out_high[63:32]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

`include "assert_macros.svh"

   key_type  key;
   logic     advance;
   logic     valid_chain [NUM_CELLS+1];
   item_type item_chain  [NUM_CELLS+1];
   item_type rsp_item;

   xtea_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   assign req_tready          = advance;
   assign valid_chain[0]      = req_tvalid;
   assign item_chain[0].mode  = req_tuser;
   assign item_chain[0].v0    = req_tdata[31:0];
   assign item_chain[0].v1    = req_tdata[63:32];

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      xtea_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .stage    (stage_const(i)),
         .key      (key),
         .valid_up (valid_chain[i]),
         .item_up  (item_chain[i]),
         .valid_dn (valid_chain[i+1]),
         .item_dn  (item_chain[i+1])
      );
   end

   xtea_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_chain[NUM_CELLS]),
      .in_item   (item_chain[NUM_CELLS]),
      .in_ready  (advance),
      .out_valid (rsp_tvalid),
      .out_item  (rsp_item),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {rsp_item.v1, rsp_item.v0};

   // a full spare slot means the output slot is occupied too
   `ASSERT_AT(a_stall_has_result, clock, reset, req_tready || rsp_tvalid, "stall without result")
   // a taken result frees the spare slot in the next cycle
   `ASSERT_NEXT(a_spare_drains, clock, reset, rsp_tvalid && rsp_tready && !req_tready, req_tready, "spare slot did not drain")
   // a key write reads back at the same address
   `ASSERT_NEXT(a_key_readback, clock, reset, csr_psel && csr_penable && csr_pwrite, csr_paddr[3:2] != $past(csr_paddr[3:2]) || csr_prdata == $past(csr_pwdata), "key readback mismatch")

endmodule

@@ rtl/xtea_csr.sv @@
module xtea_csr import xtea_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output key_type               key
);

   key_type    key_ff;
   key_type    key_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign key        = key_ff;

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_KEY_ZERO:  key_in[0] = csr_pwdata;
            REG_KEY_ONE:   key_in[1] = csr_pwdata;
            REG_KEY_TWO:   key_in[2] = csr_pwdata;
            REG_KEY_THREE: key_in[3] = csr_pwdata;
            default:       key_in = key_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KEY_ZERO:  csr_prdata = key_ff[0];
         REG_KEY_ONE:   csr_prdata = key_ff[1];
         REG_KEY_TWO:   csr_prdata = key_ff[2];
         REG_KEY_THREE: csr_prdata = key_ff[3];
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

@@ rtl/xtea_cell.sv @@
module xtea_cell import xtea_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type stage,
   input  key_type   key,
   input  logic      valid_up,
   input  item_type  item_up,
   output logic      valid_dn,
   output item_type  item_dn
);

   logic        valid_ff;
   item_type    item_ff;
   item_type    item_in;
   logic        decrypt;
   logic        upd_v0;
   logic [31:0] sum;
   logic [1:0]  key_idx;
   logic [31:0] mixed;
   logic [31:0] src;
   logic [31:0] dst;
   logic [31:0] res;

   assign decrypt = (item_up.mode == MODE_DECRYPT);
   assign sum     = decrypt ? stage.dec_sum : stage.enc_sum;
   // decryption runs the half-rounds in reverse order
   assign upd_v0  = decrypt ? stage.odd : !stage.odd;
   assign key_idx = upd_v0 ? sum[1:0] : sum[12:11];
   assign src     = upd_v0 ? item_up.v1 : item_up.v0;
   assign dst     = upd_v0 ? item_up.v0 : item_up.v1;
   assign mixed   = mix_word(src) ^ (sum + key[key_idx]);
   assign res     = decrypt ? (dst - mixed) : (dst + mixed);

   always_comb begin
      item_in = item_up;
      if (upd_v0) begin
         item_in.v0 = res;
      end else begin
         item_in.v1 = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign valid_dn = valid_ff;
   assign item_dn  = item_ff;

endmodule

@@ rtl/xtea_skid.sv @@
module xtea_skid import xtea_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_ready,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_ready
);

   logic     out_valid_ff;
   logic     out_valid_in;
   item_type out_item_ff;
   logic     spare_valid_ff;
   logic     spare_valid_in;
   item_type spare_item_ff;
   logic     push;
   logic     out_free;

   assign in_ready = !spare_valid_ff;
   assign push     = in_valid && in_ready;
   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in   = out_valid_ff;
      spare_valid_in = spare_valid_ff;
      if (out_free) begin
         if (spare_valid_ff) begin
            out_valid_in   = 1'b1;
            spare_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
         end
      end else if (push) begin
         spare_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (spare_valid_ff) begin
            out_item_ff <= spare_item_ff;
         end else if (push) begin
            out_item_ff <= in_item;
         end
      end else if (push) begin
         spare_item_ff <= in_item;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule
